// ===== rtl/i2crm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2crm_pkg
// shared types and constants of the i2c register master
// ----------------------------------------------------------------------------
package i2crm_pkg;

  localparam logic [15:0] DivReset = 16'd100;
  localparam logic [8:0]  MaxBytes = 9'd256;

  localparam logic [1:0] MODE_WR   = 2'd0;
  localparam logic [1:0] MODE_RD   = 2'd1;
  localparam logic [1:0] MODE_PING = 2'd2;

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b00_0000_0001,
    PH_START1   = 10'b00_0000_0010,
    PH_ADDR_W   = 10'b00_0000_0100,
    PH_REG      = 10'b00_0000_1000,
    PH_DATA     = 10'b00_0001_0000,
    PH_STOP_MID = 10'b00_0010_0000,
    PH_START2   = 10'b00_0100_0000,
    PH_ADDR_R   = 10'b00_1000_0000,
    PH_RECV     = 10'b01_0000_0000,
    PH_STOP_END = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] tick;
    logic [1:0]  iv;
    logic [3:0]  bit_idx;
    logic [7:0]  shift;
    logic [8:0]  left;
    logic [1:0]  mode;
    logic [6:0]  dev;
    logic [7:0]  reg_addr;
    logic        ack_ok;
  } state_t;

  // idle with both lines released and acknowledge flag set
  localparam state_t StateReset = '{
    phase:    PH_IDLE,
    tick:     '0,
    iv:       '0,
    bit_idx:  '0,
    shift:    '0,
    left:     '0,
    mode:     '0,
    dev:      '0,
    reg_addr: '0,
    ack_ok:   1'b1
  };

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy;
    logic       wdata_taken;
    logic [7:0] rdata;
    logic       rdata_valid;
    logic       rdata_last;
    logic       done;
    logic       acked;
  } result_t;

endpackage

// ===== rtl/i2crm_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2crm_ctrl
// bus sequencer: state registers and one tick of next-state logic per beat
// ----------------------------------------------------------------------------
module i2crm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [15:0]            cfg_phase_div_i,
  input  logic                   step_i,
  input  logic                   start_req_i,
  input  logic [1:0]             mode_i,
  input  logic [6:0]             dev_addr_i,
  input  logic [7:0]             reg_addr_i,
  input  logic [8:0]             byte_count_i,
  input  logic [7:0]             wdata_i,
  input  logic                   sda_in_i,
  output i2crm_pkg::result_t     res_o
);

  i2crm_pkg::state_t  s_q, s_d;
  i2crm_pkg::result_t r;
  logic [15:0] div_q;
  logic        is_send;
  logic        tick_end;
  logic        mode_ok;
  logic [8:0]  cnt;
  logic [8:0]  left_n;

  always_comb begin
    s_d      = s_q;
    r        = '0;
    cnt      = '0;
    left_n   = s_q.left;
    is_send  = (s_q.phase == i2crm_pkg::PH_ADDR_W) || (s_q.phase == i2crm_pkg::PH_REG) ||
               (s_q.phase == i2crm_pkg::PH_DATA) || (s_q.phase == i2crm_pkg::PH_ADDR_R);
    tick_end = ({1'b0, s_q.tick} + 17'd1) >= {1'b0, div_q};
    mode_ok  = (mode_i == i2crm_pkg::MODE_WR) || (mode_i == i2crm_pkg::MODE_RD) ||
               (mode_i == i2crm_pkg::MODE_PING);

    if (s_q.phase == i2crm_pkg::PH_IDLE) begin
      if (start_req_i && mode_ok) begin
        cnt = (byte_count_i > i2crm_pkg::MaxBytes) ? i2crm_pkg::MaxBytes : byte_count_i;
        if (mode_i == i2crm_pkg::MODE_RD && cnt == 9'd0) begin
          cnt = 9'd1;
        end
        s_d.mode     = mode_i;
        s_d.dev      = dev_addr_i;
        s_d.reg_addr = reg_addr_i;
        s_d.left     = cnt;
        s_d.ack_ok   = 1'b1;
        s_d.tick     = '0;
        s_d.phase    = i2crm_pkg::PH_START1;
        s_d.iv       = '0;
        s_d.bit_idx  = '0;
        s_d.shift    = '0;
      end
    end else if (tick_end) begin
      s_d.tick = '0;
      if (s_q.iv != 2'd2) begin
        if (s_q.iv == 2'd1) begin
          if (is_send && s_q.bit_idx[3] && sda_in_i) begin
            s_d.ack_ok = 1'b0;
          end
          if (s_q.phase == i2crm_pkg::PH_RECV && !s_q.bit_idx[3]) begin
            s_d.shift = {s_q.shift[6:0], sda_in_i};
            if (s_q.bit_idx[2:0] == 3'd7) begin
              r.rdata       = s_d.shift;
              r.rdata_valid = 1'b1;
              r.rdata_last  = (s_q.left <= 9'd1);
            end
          end
        end
        s_d.iv = s_q.iv + 2'd1;
      end else begin
        s_d.iv = '0;
        if ((is_send || s_q.phase == i2crm_pkg::PH_RECV) && !s_q.bit_idx[3]) begin
          s_d.bit_idx = s_q.bit_idx + 4'd1;
        end else begin
          s_d.bit_idx = '0;
          s_d.shift   = '0;
          case (s_q.phase)
            i2crm_pkg::PH_START1: begin
              s_d.phase = i2crm_pkg::PH_ADDR_W;
              s_d.shift = {s_q.dev, 1'b0};
            end
            i2crm_pkg::PH_START2: begin
              s_d.phase = i2crm_pkg::PH_ADDR_R;
              s_d.shift = {s_q.dev, 1'b1};
            end
            i2crm_pkg::PH_STOP_MID: begin
              s_d.phase = i2crm_pkg::PH_START2;
            end
            i2crm_pkg::PH_STOP_END: begin
              s_d.phase = i2crm_pkg::PH_IDLE;
              r.done    = 1'b1;
              r.acked   = s_q.ack_ok;
            end
            i2crm_pkg::PH_RECV: begin
              left_n    = (s_q.left != 9'd0) ? s_q.left - 9'd1 : s_q.left;
              s_d.left  = left_n;
              s_d.phase = (left_n == 9'd0) ? i2crm_pkg::PH_STOP_END : i2crm_pkg::PH_RECV;
            end
            i2crm_pkg::PH_ADDR_W, i2crm_pkg::PH_REG, i2crm_pkg::PH_DATA,
            i2crm_pkg::PH_ADDR_R: begin
              if (!s_q.ack_ok) begin
                s_d.phase = i2crm_pkg::PH_STOP_END;
              end else if (s_q.phase == i2crm_pkg::PH_ADDR_W) begin
                if (s_q.mode == i2crm_pkg::MODE_PING) begin
                  s_d.phase = i2crm_pkg::PH_STOP_END;
                end else begin
                  s_d.phase = i2crm_pkg::PH_REG;
                  s_d.shift = s_q.reg_addr;
                end
              end else if (s_q.phase == i2crm_pkg::PH_REG &&
                           s_q.mode == i2crm_pkg::MODE_RD) begin
                s_d.phase = i2crm_pkg::PH_STOP_MID;
              end else if (s_q.phase == i2crm_pkg::PH_ADDR_R) begin
                s_d.phase = i2crm_pkg::PH_RECV;
              end else begin
                left_n = (s_q.phase == i2crm_pkg::PH_DATA && s_q.left != 9'd0) ?
                         s_q.left - 9'd1 : s_q.left;
                s_d.left = left_n;
                if (left_n == 9'd0) begin
                  s_d.phase = i2crm_pkg::PH_STOP_END;
                end else begin
                  s_d.phase     = i2crm_pkg::PH_DATA;
                  s_d.shift     = wdata_i;
                  r.wdata_taken = 1'b1;
                end
              end
            end
            default: begin
              s_d.phase = i2crm_pkg::PH_IDLE;
            end
          endcase
        end
      end
    end else begin
      s_d.tick = s_q.tick + 16'd1;
    end

    // line levels of the interval entered
    case (s_d.phase)
      i2crm_pkg::PH_START1, i2crm_pkg::PH_START2: begin
        r.scl_release = (s_d.iv != 2'd2);
        r.sda_release = (s_d.iv == 2'd0);
      end
      i2crm_pkg::PH_STOP_MID, i2crm_pkg::PH_STOP_END: begin
        r.scl_release = (s_d.iv != 2'd0);
        r.sda_release = (s_d.iv == 2'd2);
      end
      i2crm_pkg::PH_RECV: begin
        r.scl_release = (s_d.iv == 2'd1);
        r.sda_release = !s_d.bit_idx[3] || (s_d.left <= 9'd1);
      end
      i2crm_pkg::PH_ADDR_W, i2crm_pkg::PH_REG, i2crm_pkg::PH_DATA,
      i2crm_pkg::PH_ADDR_R: begin
        r.scl_release = (s_d.iv == 2'd1);
        r.sda_release = s_d.bit_idx[3] || s_d.shift[3'd7 - s_d.bit_idx[2:0]];
      end
      default: begin
        r.scl_release = 1'b1;
        r.sda_release = 1'b1;
      end
    endcase
    r.busy = (s_d.phase != i2crm_pkg::PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q   <= i2crm_pkg::StateReset;
      div_q <= i2crm_pkg::DivReset;
    end else begin
      if (step_i) begin
        s_q <= s_d;
      end
      if (cfg_we_i) begin
        div_q <= cfg_phase_div_i;
      end
    end
  end

  assign res_o = r;

endmodule

// ===== rtl/i2crm_obuf.sv =====
// ----------------------------------------------------------------------------
// i2crm_obuf
// two-entry result buffer: output register plus skid register
// ----------------------------------------------------------------------------
module i2crm_obuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  i2crm_pkg::result_t data_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               stall_i,
  output i2crm_pkg::result_t data_o
);

  i2crm_pkg::result_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic pop;

  assign pop = out_valid_q && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= data_i;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_q <= data_i;
      end else begin
        out_q <= data_i;
      end
    end
  end

  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

// ===== rtl/i2c_register_master.sv =====
// ----------------------------------------------------------------------------
// i2c_register_master
// open-drain i2c master running register write, register read and ping
// ----------------------------------------------------------------------------
// Each input beat is one bus tick and yields exactly one result beat. A beat
// is taken every cycle while in_stall_o is low: the sequencer state register and
// the two-entry output buffer both load on the accepting edge, so in_stall_o
// rises only when both buffer entries are held by a stalled output side.
// phase_div sets the ticks per interval (0 acts as 1); each SCL bit is three
// intervals. Write phase_div only while no transaction runs.
module i2c_register_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_phase_div_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_req_i,
  input  logic [1:0]  mode_i,
  input  logic [6:0]  dev_addr_i,
  input  logic [7:0]  reg_addr_i,
  input  logic [8:0]  byte_count_i,
  input  logic [7:0]  wdata_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_release_o,
  output logic        sda_release_o,
  output logic        busy_res_o,
  output logic        wdata_taken_o,
  output logic [7:0]  rdata_o,
  output logic        rdata_valid_o,
  output logic        rdata_last_o,
  output logic        done_res_o,
  output logic        acked_o
);

  i2crm_pkg::result_t res, res_out;
  logic in_acc;
  logic full;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign in_acc      = in_valid_i && !full;

  i2crm_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_phase_div_i (cfg_phase_div_i),
    .step_i          (in_acc),
    .start_req_i     (start_req_i),
    .mode_i          (mode_i),
    .dev_addr_i      (dev_addr_i),
    .reg_addr_i      (reg_addr_i),
    .byte_count_i    (byte_count_i),
    .wdata_i         (wdata_i),
    .sda_in_i        (sda_in_i),
    .res_o           (res)
  );

  i2crm_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_acc),
    .data_i  (res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (res_out)
  );

  assign scl_release_o = res_out.scl_release;
  assign sda_release_o = res_out.sda_release;
  assign busy_res_o    = res_out.busy;
  assign wdata_taken_o = res_out.wdata_taken;
  assign rdata_o       = res_out.rdata;
  assign rdata_valid_o = res_out.rdata_valid;
  assign rdata_last_o  = res_out.rdata_last;
  assign done_res_o    = res_out.done;
  assign acked_o       = res_out.acked;

  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res.done) |-> !res.busy)
    else $error("done reported while still busy");

  a_rdata_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res.rdata_valid) |-> (res.busy && !res.done && !res.wdata_taken))
    else $error("received byte outside a read");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !out_valid_o) |=> out_valid_o)
    else $error("accepted beat not presented");

endmodule

// ===== dv/tb_i2c_register_master.sv =====
// ----------------------------------------------------------------------------
// tb_i2c_register_master
// self-checking bench for the i2c register master: bus ticks are planned
// against a cycle-exact model of the sequencer with a simple target that
// acks or refuses bytes and returns random read data; every result beat is
// compared field by field against the model, across several divider settings
// ----------------------------------------------------------------------------
module tb_i2c_register_master;
  import i2crm_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int NEVER_NACK  = 1000;
  localparam int RANDOM_NACK = -1;
  localparam int RAND_TICKS  = 900;
  localparam int IDLE_PCT    = 16;
  localparam int HOLD_AT     = 500;
  localparam int HOLD_LEN    = 400;
  localparam int QUIET_FROM  = 1800;
  localparam int QUIET_TO    = 2600;

  typedef struct packed {
    logic       start_req;
    logic [1:0] mode;
    logic [6:0] dev;
    logic [7:0] regb;
    logic [8:0] count;
    logic [7:0] wdata;
    logic       sda;
  } bus_tick_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_phase_div_i = DivReset;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        start_req_i = 1'b0;
  logic [1:0]  mode_i = MODE_WR;
  logic [6:0]  dev_addr_i = '0;
  logic [7:0]  reg_addr_i = '0;
  logic [8:0]  byte_count_i = '0;
  logic [7:0]  wdata_i = '0;
  logic        sda_in_i = 1'b1;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        scl_release_o;
  logic        sda_release_o;
  logic        busy_res_o;
  logic        wdata_taken_o;
  logic [7:0]  rdata_o;
  logic        rdata_valid_o;
  logic        rdata_last_o;
  logic        done_res_o;
  logic        acked_o;

  bus_tick_t   tick_q[$];
  result_t     outcome_q[$];
  bus_tick_t   cur_tick;
  state_t      master_st;
  state_t      plan_st;
  logic [15:0] div_now = DivReset;
  int          ticks_open = 0;
  int          planned = 0;
  int          acked_bytes = 0;
  int          bad_beats = 0;
  int unsigned cyc = 0;
  int unsigned hold_left = 0;

  i2c_register_master i_dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cyc <= cyc + 1;

  function automatic logic on_send(phase_e p);
    return p == PH_ADDR_W || p == PH_REG || p == PH_DATA || p == PH_ADDR_R;
  endfunction

  function automatic void enter_phase(inout state_t s, input phase_e p, input logic [7:0] b);
    s.phase   = p;
    s.iv      = '0;
    s.bit_idx = '0;
    s.shift   = b;
  endfunction

  function automatic state_t master_reset();
    state_t s;
    s        = '0;
    s.phase  = PH_IDLE;
    s.ack_ok = 1'b1;
    return s;
  endfunction

  // one bus tick of the sequencer, lines reflect the interval entered
  function automatic void advance_master(inout state_t s, input bus_tick_t t,
                                         input logic [15:0] div, output result_t r);
    logic [8:0] n;
    logic [1:0] lines;
    r = '0;
    if (s.phase == PH_IDLE) begin
      if (t.start_req && t.mode != MODE_NONE) begin
        n = (t.count > MaxBytes) ? MaxBytes : t.count;
        if (t.mode == MODE_RD && n == 9'd0) n = 9'd1;
        s.mode     = t.mode;
        s.dev      = t.dev;
        s.reg_addr = t.regb;
        s.left     = n;
        s.ack_ok   = 1'b1;
        s.tick     = '0;
        enter_phase(s, PH_START1, 8'h00);
      end
    end else if ({1'b0, s.tick} + 17'd1 < {1'b0, div}) begin
      s.tick = s.tick + 16'd1;
    end else begin
      s.tick = '0;
      if (s.iv != 2'd2) begin
        if (s.iv == 2'd1 && on_send(s.phase) && s.bit_idx == 4'd8 && t.sda) s.ack_ok = 1'b0;
        if (s.iv == 2'd1 && s.phase == PH_RECV && s.bit_idx < 4'd8) begin
          s.shift = {s.shift[6:0], t.sda};
          if (s.bit_idx == 4'd7) begin
            r.rdata       = s.shift;
            r.rdata_valid = 1'b1;
            r.rdata_last  = s.left <= 9'd1;
          end
        end
        s.iv = s.iv + 2'd1;
      end else if ((on_send(s.phase) || s.phase == PH_RECV) && s.bit_idx < 4'd8) begin
        s.iv      = '0;
        s.bit_idx = s.bit_idx + 4'd1;
      end else begin
        case (s.phase)
          PH_START1: enter_phase(s, PH_ADDR_W, {s.dev, 1'b0});
          PH_START2: enter_phase(s, PH_ADDR_R, {s.dev, 1'b1});
          PH_STOP_MID: enter_phase(s, PH_START2, 8'h00);
          PH_STOP_END: begin
            enter_phase(s, PH_IDLE, 8'h00);
            r.done  = 1'b1;
            r.acked = s.ack_ok;
          end
          PH_RECV: begin
            if (s.left != 9'd0) s.left = s.left - 9'd1;
            enter_phase(s, (s.left == 9'd0) ? PH_STOP_END : PH_RECV, 8'h00);
          end
          default: begin
            if (!s.ack_ok) enter_phase(s, PH_STOP_END, 8'h00);
            else if (s.phase == PH_ADDR_W) begin
              if (s.mode == MODE_PING) enter_phase(s, PH_STOP_END, 8'h00);
              else enter_phase(s, PH_REG, s.reg_addr);
            end else if (s.phase == PH_REG && s.mode == MODE_RD) begin
              enter_phase(s, PH_STOP_MID, 8'h00);
            end else if (s.phase == PH_ADDR_R) begin
              enter_phase(s, PH_RECV, 8'h00);
            end else begin
              if (s.phase == PH_DATA && s.left != 9'd0) s.left = s.left - 9'd1;
              if (s.left == 9'd0) enter_phase(s, PH_STOP_END, 8'h00);
              else begin
                enter_phase(s, PH_DATA, t.wdata);
                r.wdata_taken = 1'b1;
              end
            end
          end
        endcase
      end
    end
    case (s.phase)
      PH_IDLE: lines = 2'b11;
      PH_START1, PH_START2: lines = (s.iv == 2'd0) ? 2'b11 : (s.iv == 2'd1) ? 2'b10 : 2'b00;
      PH_STOP_MID, PH_STOP_END: lines = (s.iv == 2'd0) ? 2'b00 : (s.iv == 2'd1) ? 2'b10 : 2'b11;
      PH_RECV: lines = {s.iv == 2'd1, s.bit_idx < 4'd8 || s.left <= 9'd1};
      default: lines = {s.iv == 2'd1, (s.bit_idx < 4'd8) ? s.shift[3'd7 - s.bit_idx[2:0]] : 1'b1};
    endcase
    r.scl_release = lines[1];
    r.sda_release = lines[0];
    r.busy        = s.phase != PH_IDLE;
  endfunction

  function automatic logic take_break();
    return !(cyc >= QUIET_FROM && cyc < QUIET_TO) && $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // target side: ack unless told to refuse, random bits elsewhere
  function automatic void plan_tick(input logic start, input logic [1:0] mode,
                                    input logic [6:0] dev, input logic [7:0] regb,
                                    input logic [8:0] count, input int nack_at);
    bus_tick_t t;
    result_t   unused;
    logic      ack_bit;
    ack_bit     = on_send(plan_st.phase) && plan_st.bit_idx == 4'd8;
    t.start_req = start;
    t.mode      = mode;
    t.dev       = dev;
    t.regb      = regb;
    t.count     = count;
    t.wdata     = 8'($urandom);
    if (!ack_bit) t.sda = 1'($urandom);
    else if (nack_at == RANDOM_NACK) t.sda = $urandom_range(0, 99) < 5;
    else t.sda = acked_bytes >= nack_at;
    advance_master(plan_st, t, div_now, unused);
    if (ack_bit && !(on_send(plan_st.phase) && plan_st.bit_idx == 4'd8)) acked_bytes++;
    tick_q.push_back(t);
    ticks_open++;
    planned++;
  endfunction

  function automatic void run_xfer(input logic [1:0] mode, input logic [6:0] dev,
                                   input logic [7:0] regb, input logic [8:0] count,
                                   input int nack_at);
    acked_bytes = 0;
    plan_tick(1'b1, mode, dev, regb, count, nack_at);
    while (plan_st.phase != PH_IDLE)
      plan_tick(1'($urandom), 2'($urandom), 7'($urandom), 8'($urandom), 9'($urandom), nack_at);
  endfunction

  function automatic void idle_noise(input int n);
    logic s;
    repeat (n) begin
      s = 1'($urandom);
      plan_tick(s, s ? MODE_NONE : 2'($urandom), 7'($urandom), 8'($urandom), 9'($urandom),
                NEVER_NACK);
    end
  endfunction

  task automatic settle();
    do @(posedge clk_i); while (ticks_open != 0 || outcome_q.size() != 0);
  endtask

  task automatic write_div(input logic [15:0] v);
    settle();
    cfg_valid_i     <= 1'b1;
    cfg_phase_div_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    div_now = v;
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] seen);
    if (want !== seen) begin
      bad_beats++;
      if (bad_beats <= 10)
        $display("cycle %0d: %s expected %0h got %0h", cyc, name, want, seen);
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    result_t r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        advance_master(master_st, cur_tick, div_now, r);
        outcome_q.push_back(r);
        ticks_open--;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tick_q.size() != 0 && !take_break()) begin
          cur_tick = tick_q.pop_front();
          in_valid_i   <= 1'b1;
          start_req_i  <= cur_tick.start_req;
          mode_i       <= cur_tick.mode;
          dev_addr_i   <= cur_tick.dev;
          reg_addr_i   <= cur_tick.regb;
          byte_count_i <= cur_tick.count;
          wdata_i      <= cur_tick.wdata;
          sda_in_i     <= cur_tick.sda;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (cyc == HOLD_AT) begin
      hold_left   <= HOLD_LEN;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= take_break();
    end
  end

  // monitor
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (outcome_q.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10) $display("cycle %0d: result beat with nothing outstanding", cyc);
      end else begin
        want = outcome_q.pop_front();
        check_field("scl_release", want.scl_release, scl_release_o);
        check_field("sda_release", want.sda_release, sda_release_o);
        check_field("busy_res", want.busy, busy_res_o);
        check_field("wdata_taken", want.wdata_taken, wdata_taken_o);
        check_field("rdata", want.rdata, rdata_o);
        check_field("rdata_valid", want.rdata_valid, rdata_valid_o);
        check_field("rdata_last", want.rdata_last, rdata_last_o);
        check_field("done_res", want.done, done_res_o);
        check_field("acked", want.acked, acked_o);
      end
    end
  end

  initial begin
    int          base;
    logic [15:0] d;
    logic [1:0]  m;
    logic [8:0]  n;
    master_st = master_reset();
    plan_st   = master_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idle ticks at the reset divider
    idle_noise(8);

    // zero divider acts as one
    write_div(16'd0);
    run_xfer(MODE_PING, 7'h7f, 8'hff, 9'h1ff, 0);
    run_xfer(MODE_PING, 7'h00, 8'h00, 9'd0, NEVER_NACK);
    run_xfer(MODE_WR, 7'h55, 8'hff, 9'd0, NEVER_NACK);
    run_xfer(MODE_RD, 7'h2a, 8'h00, 9'd0, NEVER_NACK);
    run_xfer(MODE_WR, 7'h7f, 8'h00, 9'd3, 2);
    run_xfer(MODE_RD, 7'h11, 8'h80, 9'd2, 1);
    run_xfer(MODE_RD, 7'h22, 8'h01, 9'd2, 2);
    run_xfer(MODE_NONE, 7'h33, 8'h44, 9'd5, NEVER_NACK);
    run_xfer(MODE_WR, 7'h0f, 8'h5a, 9'h1ff, 3);
    run_xfer(MODE_RD, 7'h70, 8'ha5, 9'd5, NEVER_NACK);
    run_xfer(MODE_WR, 7'h01, 8'h7e, 9'd2, NEVER_NACK);

    // widest divider, idle only
    write_div(16'hffff);
    idle_noise(40);

    base = planned;
    while (planned - base < RAND_TICKS) begin
      d = 16'($urandom_range(0, 5));
      if (d > 16'd3) d = 16'd1;
      write_div(d);
      repeat (2) begin
        idle_noise($urandom_range(0, 3));
        m = ($urandom_range(0, 19) == 0) ? MODE_NONE : 2'($urandom_range(0, 2));
        n = ($urandom_range(0, 6) == 0) ? 9'($urandom_range(4, 12)) : 9'($urandom_range(0, 3));
        run_xfer(m, 7'($urandom), 8'($urandom), n, RANDOM_NACK);
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (bad_beats == 0) $display("tb_i2c_register_master OK");
    else $display("tb_i2c_register_master NOT OK");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_i2c_register_master NOT OK");
    $finish;
  end

endmodule
